/* hw/rtl/coin_change_way_counter_core_assert.svh */
// Assertion macros used by the coin change way counter datapath.
`ifndef COIN_CHANGE_WAY_COUNTER_CORE_ASSERT_SVH
`define COIN_CHANGE_WAY_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CCWC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ccwc: assertion failed");
`define CCWC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccwc: assertion failed");
`else
`define CCWC_ASSERT(label, prop)
`define CCWC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/ccwc_pkg.sv */
// Shared constants, types and microcode encoding for the coin change way counter.
package ccwc_pkg;

   localparam int AMT_W        = 12;
   localparam int COUNT_W      = 64;
   localparam int AMOUNT_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(AMOUNT_DEPTH);
   localparam int J_W          = AMT_W + 1;
   localparam int REG_COUNT    = 8;
   localparam int REG_IDX_W    = 3;
   localparam int COIN_SLOTS   = 8;
   localparam int SLOT_W       = (COIN_SLOTS > 1) ? $clog2(COIN_SLOTS) : 1;
   localparam int PADDR_W      = REG_IDX_W + 2;
   localparam int PDATA_W      = 32;
   localparam int STEP_W       = 4;

   typedef logic [AMT_W-1:0]   amount_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef amount_type [REG_COUNT-1:0] coin_array_type;
   typedef logic [STEP_W-1:0]  step_type;

   // Datapath operations issued by the control word
   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_NONE,
      OP_CLEAR,
      OP_COIN,
      OP_READ,
      OP_WRITE,
      OP_NEXT,
      OP_FETCH,
      OP_RESULT
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_REQ_FIRE,
      COND_OOR,
      COND_J_MORE,
      COND_COIN_SKIP,
      COND_SLOT_LAST,
      COND_OUT_BUSY
   } cond_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_CHECK  = 4'd1;
   localparam step_type STEP_CLEAR  = 4'd2;
   localparam step_type STEP_COIN   = 4'd3;
   localparam step_type STEP_READ   = 4'd4;
   localparam step_type STEP_WRITE  = 4'd5;
   localparam step_type STEP_NEXT   = 4'd6;
   localparam step_type STEP_FETCH  = 4'd7;
   localparam step_type STEP_RESULT = 4'd8;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_step;
      step_type seq_step;
   } ucode_type;

   typedef struct packed {
      logic req_fire;
      logic oor;
      logic j_more;
      logic coin_skip;
      logic slot_last;
      logic out_busy;
   } status_type;

   function automatic amount_type coin_reset(input logic [REG_IDX_W-1:0] idx);
      amount_type val;
      case (idx)
         3'd0:    val = 12'd1;
         3'd1:    val = 12'd2;
         3'd2:    val = 12'd5;
         3'd3:    val = 12'd10;
         3'd4:    val = 12'd20;
         3'd5:    val = 12'd50;
         3'd6:    val = 12'd100;
         default: val = 12'd200;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/ccwc_csr.sv */
// APB register file holding the coin denominations.
module ccwc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ccwc_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [ccwc_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [ccwc_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                              csr_pready,
   output ccwc_pkg::coin_array_type          coins
);
   import ccwc_pkg::*;

   coin_array_type coin_ff, coin_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx = csr_paddr[PADDR_W-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      coin_in = coin_ff;
      if (wr_en) begin
         coin_in[reg_idx] = csr_pwdata[AMT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coin_ff[i] <= coin_reset(REG_IDX_W'(i));
         end
      end else begin
         coin_ff <= coin_in;
      end
   end

   assign csr_prdata = PDATA_W'(coin_ff[reg_idx]);
   assign csr_pready = 1'b1;
   assign coins      = coin_ff;

endmodule

/* hw/rtl/ccwc_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module ccwc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ccwc_pkg::status_type   status,
   output ccwc_pkg::ucode_type    ctrl
);
   import ccwc_pkg::*;

   step_type pc_ff, pc_in;
   logic     take_jump;

   // Control store
   always_comb begin
      unique case (pc_ff)
         STEP_IDLE:   ctrl = '{OP_ACCEPT, COND_REQ_FIRE,  STEP_CHECK,  STEP_IDLE};
         STEP_CHECK:  ctrl = '{OP_NONE,   COND_OOR,       STEP_RESULT, STEP_CLEAR};
         STEP_CLEAR:  ctrl = '{OP_CLEAR,  COND_J_MORE,    STEP_CLEAR,  STEP_COIN};
         STEP_COIN:   ctrl = '{OP_COIN,   COND_COIN_SKIP, STEP_NEXT,   STEP_READ};
         STEP_READ:   ctrl = '{OP_READ,   COND_NEVER,     STEP_READ,   STEP_WRITE};
         STEP_WRITE:  ctrl = '{OP_WRITE,  COND_J_MORE,    STEP_READ,   STEP_NEXT};
         STEP_NEXT:   ctrl = '{OP_NEXT,   COND_SLOT_LAST, STEP_FETCH,  STEP_COIN};
         STEP_FETCH:  ctrl = '{OP_FETCH,  COND_NEVER,     STEP_FETCH,  STEP_RESULT};
         STEP_RESULT: ctrl = '{OP_RESULT, COND_OUT_BUSY,  STEP_RESULT, STEP_IDLE};
         default:     ctrl = '{OP_NONE,   COND_NEVER,     STEP_IDLE,   STEP_IDLE};
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_REQ_FIRE:  take_jump = status.req_fire;
         COND_OOR:       take_jump = status.oor;
         COND_J_MORE:    take_jump = status.j_more;
         COND_COIN_SKIP: take_jump = status.coin_skip;
         COND_SLOT_LAST: take_jump = status.slot_last;
         COND_OUT_BUSY:  take_jump = status.out_busy;
         default:        take_jump = 1'b0;
      endcase
   end

   assign pc_in = take_jump ? ctrl.jump_step : ctrl.seq_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* hw/rtl/ccwc_dp.sv */
// Datapath: row memory, amount and slot counters, adder and result register.
`include "coin_change_way_counter_core_assert.svh"
module ccwc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ccwc_pkg::amount_type          req_target_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ccwc_pkg::count_type           rsp_way_count,
   input  ccwc_pkg::coin_array_type      coins,
   input  ccwc_pkg::ucode_type           ctrl,
   output ccwc_pkg::status_type          status
);
   import ccwc_pkg::*;

   count_type ways_row [AMOUNT_DEPTH];

   amount_type          target_ff, target_in;
   logic                oor_ff, oor_in;
   logic [J_W-1:0]      j_ff, j_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   count_type           rd_a_ff, rd_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   count_type           rsp_count_ff, rsp_count_in;

   amount_type          coin_cur;
   logic [J_W-1:0]      coin_ext;
   logic                req_fire, out_busy;
   logic                wr_en, rd_a_en, rd_b_en;
   logic [ADDR_W-1:0]   wr_addr, rd_a_addr, rd_b_addr;
   logic [J_W-1:0]      j_back;
   count_type           wr_data;

   assign coin_cur  = coins[slot_ff];
   assign coin_ext  = {1'b0, coin_cur};
   assign req_stall = (ctrl.op != OP_ACCEPT);
   assign req_fire  = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign j_back    = j_ff - coin_ext;

   assign status.req_fire  = req_fire;
   assign status.oor       = oor_ff;
   assign status.j_more    = (j_ff != {1'b0, target_ff});
   assign status.coin_skip = (coin_cur == '0) || (coin_cur > target_ff);
   assign status.slot_last = (slot_ff == SLOT_W'(COIN_SLOTS - 1));
   assign status.out_busy  = out_busy;

   always_comb begin
      target_in    = target_ff;
      oor_in       = oor_ff;
      j_in         = j_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      case (ctrl.op) inside
         OP_ACCEPT: begin
            if (req_fire) begin
               target_in = req_target_amount;
               oor_in    = ({1'b0, req_target_amount} >= J_W'(AMOUNT_DEPTH));
               j_in      = '0;
               slot_in   = '0;
            end
         end
         OP_CLEAR, OP_WRITE: j_in = j_ff + 1'b1;
         OP_COIN:            j_in = coin_ext;
         OP_NEXT:            slot_in = slot_ff + 1'b1;
         OP_RESULT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = oor_ff ? '0 : rd_a_ff;
            end
         end
         default: ;
      endcase
   end

   // Row memory port control
   assign wr_en     = (ctrl.op == OP_CLEAR) || (ctrl.op == OP_WRITE);
   assign wr_addr   = j_ff[ADDR_W-1:0];
   assign wr_data   = (ctrl.op == OP_CLEAR) ? ((j_ff == '0) ? COUNT_W'(1) : '0)
                                            : (rd_a_ff + rd_b_ff);
   assign rd_a_en   = (ctrl.op == OP_READ) || (ctrl.op == OP_FETCH);
   assign rd_a_addr = (ctrl.op == OP_FETCH) ? target_ff[ADDR_W-1:0] : j_ff[ADDR_W-1:0];
   assign rd_b_en   = (ctrl.op == OP_READ);
   assign rd_b_addr = j_back[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ways_row[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= ways_row[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= ways_row[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         oor_ff       <= 1'b0;
         j_ff         <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         oor_ff       <= oor_in;
         j_ff         <= j_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_way_count = rsp_count_ff;

   // the lagging entry must lie inside the row already built
   `CCWC_ASSERT(a_read_behind, (ctrl.op == OP_READ) |-> (coin_cur != '0 && j_ff >= coin_ext))
   // row writes never run past the requested amount
   `CCWC_ASSERT(a_write_bound, wr_en |-> (j_ff <= {1'b0, target_ff}))
   // a new result only comes out of the result step
   `CCWC_ASSERT_NEXT(a_result_src, !rsp_valid_ff && ctrl.op != OP_RESULT, !rsp_valid_ff)

endmodule

/* hw/rtl/coin_change_way_counter_core.sv */
// Top level of the coin change way counter.
// For target T a transaction clears row entries 0..T, then for each active coin c <= T
// walks the row from c to T: read two entries, then add and write one.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// The worst case transaction is bounded by the single row memory of 4096 entries.
// Synchronous active-high reset returns the coin registers to 1,2,5,10,20,50,100,200.
module coin_change_way_counter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ccwc_pkg::amount_type              req_target_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ccwc_pkg::count_type               rsp_way_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ccwc_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [ccwc_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [ccwc_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import ccwc_pkg::*;

   coin_array_type coins;
   ucode_type      ctrl;
   status_type     status;

   ccwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coins       (coins)
   );

   ccwc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   ccwc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_amount (req_target_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_way_count     (rsp_way_count),
      .coins             (coins),
      .ctrl              (ctrl),
      .status            (status)
   );

endmodule

/* tb/coin_change_way_counter_core_test.sv */
`timescale 1ns / 100ps
// Testbench for the coin change way counter: coin sets and amounts checked against a row-based count.
module coin_change_way_counter_core_test;
   import ccwc_pkg::*;

   localparam int IDLE_PERCENT   = 23;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 12;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {
      REG_COIN_A,
      REG_COIN_B,
      REG_COIN_C,
      REG_COIN_D,
      REG_COIN_E,
      REG_COIN_F,
      REG_COIN_G,
      REG_COIN_H
   } coin_reg_type;

   class way_count_board;
      amount_type coin [REG_COUNT];
      count_type  row [AMOUNT_DEPTH];
      count_type  expected_counts [$];
      int         failures;

      function new();
         coin     = '{12'd1, 12'd2, 12'd5, 12'd10, 12'd20, 12'd50, 12'd100, 12'd200};
         failures = 0;
      endfunction

      // Single-row table: clear up to the target, then fold in each coin in slot order
      function count_type count_ways(amount_type target);
         if (int'(target) >= AMOUNT_DEPTH) return '0;
         row[0] = 64'd1;
         for (int j = 1; j <= int'(target); j++) row[j] = '0;
         for (int s = 0; s < COIN_SLOTS; s++) begin
            if (coin[s] != '0) begin
               for (int j = int'(coin[s]); j <= int'(target); j++)
                  row[j] += row[j - int'(coin[s])];
            end
         end
         return row[target];
      endfunction

      function void note_target(amount_type target);
         expected_counts.push_back(count_ways(target));
      endfunction

      function void check_count(count_type seen);
         count_type want;
         if (expected_counts.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("way_count 0x%h with no transaction outstanding", seen);
         end else begin
            want = expected_counts.pop_front();
            if (seen !== want) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("way_count mismatch: expected 0x%h, got 0x%h", want, seen);
            end
         end
      endfunction
   endclass

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   amount_type          req_target_amount = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   count_type           rsp_way_count;
   logic                csr_psel          = 1'b0;
   logic                csr_penable       = 1'b0;
   logic                csr_pwrite        = 1'b0;
   logic [PADDR_W-1:0]  csr_paddr         = '0;
   logic [PDATA_W-1:0]  csr_pwdata        = '0;
   logic [PDATA_W-1:0]  csr_prdata;
   logic                csr_pready;

   way_count_board board = new();
   bit             calm  = 1'b0;
   int             quiet_cycles = 0;

   coin_change_way_counter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_amount (req_target_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_way_count     (rsp_way_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_count(rsp_way_count);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL coin_change_way_counter_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // valid stays high across back-to-back transactions; only lowered for an idle gap or by drain
   task automatic send_target(input amount_type target);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PERCENT) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_target_amount <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_target(target);
   endtask

   task automatic run_targets(input amount_type targets [$]);
      foreach (targets[k]) send_target(targets[k]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_counts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_coin(input coin_reg_type idx, input logic [PDATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_W'(int'(idx) << 2);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      board.coin[idx] = data[AMT_W-1:0];
   endtask

   // upper data bits are junk; the register keeps the low 12
   task automatic set_coins(input amount_type values [REG_COUNT]);
      for (int i = 0; i < REG_COUNT; i++)
         write_coin(coin_reg_type'(i), {20'($urandom), values[i]});
   endtask

   function automatic amount_type pick_coin();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return '0;
      if (roll < 60) return amount_type'($urandom_range(20, 1));
      if (roll < 85) return amount_type'($urandom_range(300, 21));
      return amount_type'($urandom_range(4095, 301));
   endfunction

   // mostly short rows; a full-range amount now and then
   function automatic amount_type pick_target();
      if ($urandom_range(24) == 0) return amount_type'($urandom);
      return amount_type'($urandom_range(150));
   endfunction

   initial begin
      amount_type coin_set [REG_COUNT];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coin set from reset
      run_targets('{12'd0, 12'd1, 12'd2, 12'd4, 12'd5, 12'd11, 12'd100, 12'd200, 12'd4095});
      drain();
      // eight unit coins: the count for the top amount wraps past 64 bits
      set_coins('{default: 12'd1});
      run_targets('{12'd4095});
      drain();
      // unused slots, widest coin, coins above the amount
      set_coins('{12'd0, 12'd3, 12'd0, 12'd7, 12'd4095, 12'd0, 12'd2048, 12'd1});
      run_targets('{12'd0, 12'd1, 12'd6, 12'd21, 12'd2048, 12'd4095});
      drain();
      set_coins('{default: 12'd0});
      run_targets('{12'd0, 12'd7, 12'd4095});
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         calm = (p == 2);
         for (int i = 0; i < REG_COUNT; i++) coin_set[i] = pick_coin();
         set_coins(coin_set);
         for (int i = 0; i < PHASE_ITEMS; i++) send_target(pick_target());
         drain();
      end

      calm = 1'b0;
      repeat (40) @(posedge clock);
      if (board.failures == 0) begin
         $display("PASS coin_change_way_counter_core");
      end else begin
         $display("FAIL coin_change_way_counter_core");
      end
      $finish;
   end

endmodule
